// ----- rtl/cache_tag_lookup_fifo_lru_top_macros.svh -----
// Assertion macros shared by the cache tag lookup checker.
// No dependencies; include by bare file name.
`ifndef CACHE_TAG_LOOKUP_FIFO_LRU_TOP_MACROS_SVH
`define CACHE_TAG_LOOKUP_FIFO_LRU_TOP_MACROS_SVH

// same-cycle implication
`define CTL_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cache tag lookup assertion failed");

// next-cycle implication
`define CTL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cache tag lookup assertion failed");

`endif

// ----- rtl/ctl_pkg.sv -----
// Shared types and constants for the cache tag lookup block.
// No dependencies.
package ctl_pkg;

   localparam int MaxBlocks     = 256;
   localparam int AddrW         = $clog2(MaxBlocks);
   localparam int MaxBlocksLog2 = AddrW;
   localparam int SetWaysLog2   = 2;
   localparam int TagW          = 30;
   localparam int ByteAddrW     = 32;
   localparam int CntW          = 32;
   localparam int OffsetBase    = 2;
   localparam int CfgIndexW     = 2;
   localparam int CfgDataW      = 4;

   typedef logic [AddrW:0] span_type;

   typedef enum logic [CfgIndexW-1:0] {
      CFG_NUM_BLOCKS_LOG2,
      CFG_BLOCK_WORDS_LOG2,
      CFG_ORGANIZATION,
      CFG_REPLACE_POLICY
   } cfg_index_type;

   typedef enum logic [1:0] {
      ORG_DIRECT,
      ORG_SET_ASSOC,
      ORG_FULL_ASSOC
   } org_type;

   typedef enum logic {
      POL_FIFO,
      POL_LRU
   } policy_type;

   typedef enum logic [1:0] {
      OUT_HIT,
      OUT_FILL,
      OUT_EVICT
   } outcome_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [3:0] num_blocks_log2;
      logic [3:0] block_words_log2;
      logic [1:0] organization;
      logic       replace_policy;
   } cfg_type;

   // one decoded access
   typedef struct packed {
      logic [TagW-1:0]  tag;
      logic [AddrW-1:0] base;
      logic [AddrW-1:0] ways_m1;
      logic             lru;
   } lookup_type;

   // tag RAM port requests
   typedef struct packed {
      logic             wr_en;
      logic [AddrW-1:0] wr_addr;
      logic [TagW-1:0]  wr_data;
      logic             rd_en;
      logic [AddrW-1:0] rd_addr;
   } ram_req_type;

endpackage

// ----- rtl/ctl_tag_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the tag store.
module ctl_tag_ram #(
   parameter int AddrWidth = 8,
   parameter int DataWidth = 30
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AddrWidth-1:0] wr_addr,
   input  logic [DataWidth-1:0] wr_data,
   input  logic                 rd_en,
   input  logic [AddrWidth-1:0] rd_addr,
   output logic [DataWidth-1:0] rd_data
);

   logic [DataWidth-1:0] mem [2**AddrWidth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ----- rtl/ctl_cfg_decode.sv -----
// Configuration registers and address split into tag, set base and way count.
// Depends on ctl_pkg.
module ctl_cfg_decode
   import ctl_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CfgIndexW-1:0] csr_index,
   input  logic [CfgDataW-1:0]  csr_wdata,
   input  logic [ByteAddrW-1:0] byte_address,
   output lookup_type           lookup
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   logic [3:0]           n_eff;
   logic [3:0]           ways_log2;
   logic [3:0]           idx_w;
   logic [4:0]           off_w;
   logic [ByteAddrW-1:0] shifted;
   logic [ByteAddrW-1:0] tag_shifted;
   logic [AddrW-1:0]     idx_mask;
   logic [AddrW-1:0]     idx;

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (cfg_index_type'(csr_index))
            CFG_NUM_BLOCKS_LOG2:  cfg_in.num_blocks_log2  = csr_wdata;
            CFG_BLOCK_WORDS_LOG2: cfg_in.block_words_log2 = csr_wdata;
            CFG_ORGANIZATION:     cfg_in.organization     = csr_wdata[1:0];
            CFG_REPLACE_POLICY:   cfg_in.replace_policy   = csr_wdata[0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.num_blocks_log2  <= 4'(MaxBlocksLog2);
         cfg_ff.block_words_log2 <= '0;
         cfg_ff.organization     <= ORG_DIRECT;
         cfg_ff.replace_policy   <= POL_FIFO;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // geometry: block count clipped to the store, ways per set
   always_comb begin
      n_eff = (cfg_ff.num_blocks_log2 > 4'(MaxBlocksLog2)) ?
              4'(MaxBlocksLog2) : cfg_ff.num_blocks_log2;
      unique case (cfg_ff.organization)
         ORG_DIRECT:    ways_log2 = '0;
         ORG_SET_ASSOC: ways_log2 = (n_eff < 4'(SetWaysLog2)) ? n_eff : 4'(SetWaysLog2);
         default:       ways_log2 = n_eff;  // fully associative, code three too
      endcase
      idx_w = n_eff - ways_log2;
      off_w = {1'b0, cfg_ff.block_words_log2} + 5'(OffsetBase);
   end

   // address split
   always_comb begin
      shifted     = byte_address >> off_w;
      tag_shifted = byte_address >> (6'(off_w) + 6'(idx_w));
      idx_mask    = AddrW'((span_type'(1) << idx_w) - span_type'(1));
      idx         = shifted[AddrW-1:0] & idx_mask;

      lookup.tag     = tag_shifted[TagW-1:0];
      lookup.base    = idx << ways_log2;
      lookup.ways_m1 = AddrW'((span_type'(1) << ways_log2) - span_type'(1));
      lookup.lru     = cfg_ff.replace_policy;
   end

endmodule

// ----- rtl/ctl_lookup_seq.sv -----
// Lookup sequencer: way scan, fill, evict and LRU reorder over the tag RAM,
// valid bits, running counters and the result register. Depends on ctl_pkg.
module ctl_lookup_seq
   import ctl_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  lookup_type       lookup,
   output ram_req_type      ram_req,
   input  logic [TagW-1:0]  rd_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [1:0]       rsp_outcome,
   output logic [TagW-1:0]  rsp_victim_tag,
   output logic [CntW-1:0]  rsp_access_count,
   output logic [CntW-1:0]  rsp_miss_count
);

   state_type        state_ff, state_in;
   lookup_type       lk_ff, lk_in;
   logic [AddrW-1:0] ptr_ff, ptr_in;
   logic             pend_ff, pend_in;
   logic             last_ff, last_in;
   logic [AddrW-1:0] cmp_way_ff, cmp_way_in;
   logic [TagW-1:0]  victim_ff, victim_in;
   outcome_type      outcome_ff, outcome_in;
   logic [MaxBlocks-1:0] valid_ff, valid_in;
   logic [CntW-1:0]  acc_ff, acc_in;
   logic [CntW-1:0]  miss_ff, miss_in;
   logic             rsp_valid_ff, rsp_valid_in;
   outcome_type      rsp_outcome_ff, rsp_outcome_in;
   logic [TagW-1:0]  rsp_victim_ff, rsp_victim_in;

   span_type         off;
   logic             in_range;
   logic [AddrW-1:0] vaddr;
   logic             vbit;

   // shared way address: current way in scan, next way ahead in shift
   always_comb begin
      if (state_ff == ST_SHIFT) begin
         off = span_type'(ptr_ff) + (pend_ff ? span_type'(2) : span_type'(1));
      end else begin
         off = span_type'(ptr_ff);
      end
      in_range = (off <= span_type'(lk_ff.ways_m1));
      vaddr    = lk_ff.base + off[AddrW-1:0];
      vbit     = valid_ff[vaddr];
   end

   // next state and datapath control
   always_comb begin
      state_in       = state_ff;
      lk_in          = lk_ff;
      ptr_in         = ptr_ff;
      pend_in        = pend_ff;
      last_in        = last_ff;
      cmp_way_in     = cmp_way_ff;
      victim_in      = victim_ff;
      outcome_in     = outcome_ff;
      valid_in       = valid_ff;
      acc_in         = acc_ff;
      miss_in        = miss_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_outcome_in = rsp_outcome_ff;
      rsp_victim_in  = rsp_victim_ff;

      ram_req.wr_en   = 1'b0;
      ram_req.wr_addr = lk_ff.base + ptr_ff;
      ram_req.wr_data = lk_ff.tag;
      ram_req.rd_en   = 1'b0;
      ram_req.rd_addr = vaddr;

      // result word taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               lk_in    = lookup;
               ptr_in   = '0;
               pend_in  = 1'b0;
               last_in  = 1'b0;
               state_in = ST_SCAN;
            end
         end

         ST_SCAN: begin
            // way 0 is the victim if the set turns out full
            if (pend_ff && cmp_way_ff == '0) begin
               victim_in = rd_data;
            end
            priority if (pend_ff && rd_data == lk_ff.tag) begin
               outcome_in = OUT_HIT;
               if (lk_ff.lru == POL_LRU) begin
                  ptr_in   = cmp_way_ff;
                  pend_in  = 1'b0;
                  state_in = ST_SHIFT;
               end else begin
                  state_in = ST_DONE;
               end
            end else if (pend_ff && last_ff) begin
               // set full, no match
               outcome_in = OUT_EVICT;
               ptr_in     = '0;
               pend_in    = 1'b0;
               state_in   = ST_SHIFT;
            end else if (!vbit) begin
               // first empty way takes the tag
               ram_req.wr_en   = 1'b1;
               ram_req.wr_addr = vaddr;
               valid_in[vaddr] = 1'b1;
               outcome_in      = OUT_FILL;
               state_in        = ST_DONE;
            end else begin
               ram_req.rd_en = 1'b1;
               pend_in       = 1'b1;
               cmp_way_in    = ptr_ff;
               if (ptr_ff == lk_ff.ways_m1) begin
                  last_in = 1'b1;
               end else begin
                  ptr_in = ptr_ff + AddrW'(1);
               end
            end
         end

         ST_SHIFT: begin
            // move younger ways down one place while the next way is valid
            if (!pend_ff) begin
               if (in_range && vbit) begin
                  ram_req.rd_en = 1'b1;
                  pend_in       = 1'b1;
               end else begin
                  ram_req.wr_en = 1'b1;
                  state_in      = ST_DONE;
               end
            end else begin
               ram_req.wr_en   = 1'b1;
               ram_req.wr_data = rd_data;
               ptr_in          = ptr_ff + AddrW'(1);
               if (in_range && vbit) begin
                  ram_req.rd_en = 1'b1;
               end else begin
                  pend_in = 1'b0;
               end
            end
         end

         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               acc_in         = acc_ff + CntW'(1);
               miss_in        = miss_ff + CntW'(outcome_ff != OUT_HIT);
               rsp_valid_in   = 1'b1;
               rsp_outcome_in = outcome_ff;
               rsp_victim_in  = (outcome_ff == OUT_EVICT) ? victim_ff : '0;
               state_in       = ST_IDLE;
            end
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         acc_ff       <= '0;
         miss_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         acc_ff       <= acc_in;
         miss_ff      <= miss_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload and sequencing registers
   always_ff @(posedge clock) begin
      lk_ff          <= lk_in;
      ptr_ff         <= ptr_in;
      pend_ff        <= pend_in;
      last_ff        <= last_in;
      cmp_way_ff     <= cmp_way_in;
      victim_ff      <= victim_in;
      outcome_ff     <= outcome_in;
      rsp_outcome_ff <= rsp_outcome_in;
      rsp_victim_ff  <= rsp_victim_in;
   end

   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_outcome      = rsp_outcome_ff;
   assign rsp_victim_tag   = rsp_victim_ff;
   assign rsp_access_count = acc_ff;
   assign rsp_miss_count   = miss_ff;

endmodule

// ----- rtl/cache_tag_lookup_fifo_lru_top.sv -----
// Cache tag lookup, FIFO or LRU replacement. A lookup scans the ways of its set
// (one tag RAM read a cycle), then on an LRU hit or an eviction reorders the
// set, then posts the result word; posting waits while the previous result
// word is still stalled. One word in flight: a new word is taken only once the
// previous one has posted its result. Synchronous reset clears valid bits,
// counters and the result register at once; the tag RAM is not cleared.
module cache_tag_lookup_fifo_lru_top
   import ctl_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [ByteAddrW-1:0] req_byte_address,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [1:0]           rsp_outcome,
   output logic [TagW-1:0]      rsp_victim_tag,
   output logic [CntW-1:0]      rsp_access_count,
   output logic [CntW-1:0]      rsp_miss_count,
   input  logic                 csr_we,
   input  logic [CfgIndexW-1:0] csr_index,
   input  logic [CfgDataW-1:0]  csr_wdata
);

   lookup_type      lookup;
   ram_req_type     ram_req;
   logic [TagW-1:0] rd_data;

   ctl_cfg_decode u_decode (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .byte_address (req_byte_address),
      .lookup       (lookup)
   );

   ctl_tag_ram #(
      .AddrWidth (AddrW),
      .DataWidth (TagW)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (ram_req.wr_en),
      .wr_addr (ram_req.wr_addr),
      .wr_data (ram_req.wr_data),
      .rd_en   (ram_req.rd_en),
      .rd_addr (ram_req.rd_addr),
      .rd_data (rd_data)
   );

   ctl_lookup_seq u_seq (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .lookup           (lookup),
      .ram_req          (ram_req),
      .rd_data          (rd_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_outcome      (rsp_outcome),
      .rsp_victim_tag   (rsp_victim_tag),
      .rsp_access_count (rsp_access_count),
      .rsp_miss_count   (rsp_miss_count)
   );

endmodule

// ----- rtl/ctl_checker.sv -----
// Port-level checks for the cache tag lookup top level, bound to it.
// Depends on ctl_pkg and cache_tag_lookup_fifo_lru_top_macros.svh.
`include "cache_tag_lookup_fifo_lru_top_macros.svh"

module ctl_checker
   import ctl_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input logic [1:0]       rsp_outcome,
   input logic [TagW-1:0]  rsp_victim_tag,
   input logic [CntW-1:0]  rsp_access_count
);

   logic req_take;
   logic rsp_wait;
   logic rsp_no_evict;

   assign req_take     = req_valid && !req_stall;
   assign rsp_wait     = rsp_valid && rsp_stall;
   assign rsp_no_evict = rsp_valid && (rsp_outcome != OUT_EVICT);

   // one word at a time: busy right after taking a word
   `CTL_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_take, req_stall)

   // victim tag is zero unless a way was evicted
   `CTL_ASSERT_IMPLY(a_victim_only_on_evict, clock, reset, rsp_no_evict, rsp_victim_tag == '0)

   // stalled result holds
   `CTL_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_wait, rsp_valid && $stable(rsp_access_count))

   // reset empties the result register
   `CTL_ASSERT_NEXT(a_reset_clears_rsp, clock, 1'b0, reset, !rsp_valid)

endmodule

bind cache_tag_lookup_fifo_lru_top ctl_checker u_checker (.*);

// ----- sim/tb_cache_tag_lookup_fifo_lru_top.sv -----
// Self-checking bench for the cache tag lookup block: drives byte addresses,
// predicts hit/fill/evict outcomes and counters, and compares every result word.
// Depends on ctl_pkg and cache_tag_lookup_fifo_lru_top.
`timescale 1ns / 100ps

module tb_cache_tag_lookup_fifo_lru_top;
   import ctl_pkg::*;

   // organization code with no enum member; decodes as fully associative
   localparam logic [1:0] OrgReserved = 2'd3;

   typedef struct {
      outcome_type          outcome;
      logic [TagW-1:0]      victim_tag;
      logic [CntW-1:0]      access_count;
      logic [CntW-1:0]      miss_count;
   } lookup_result_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [ByteAddrW-1:0] req_byte_address = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [1:0]           rsp_outcome;
   logic [TagW-1:0]      rsp_victim_tag;
   logic [CntW-1:0]      rsp_access_count;
   logic [CntW-1:0]      rsp_miss_count;
   logic                 csr_we = 1'b0;
   logic [CfgIndexW-1:0] csr_index = '0;
   logic [CfgDataW-1:0]  csr_wdata = '0;

   // shadow copy of the cache state
   cfg_type              shadow_cfg;
   logic [TagW-1:0]      shadow_tags [MaxBlocks];
   bit                   shadow_valid [MaxBlocks];
   logic [CntW-1:0]      shadow_accesses;
   logic [CntW-1:0]      shadow_misses;

   lookup_result_type    pending_lookups [$];
   int                   mismatch_count = 0;
   bit                   req_quiet = 1'b0;
   bit                   rsp_quiet = 1'b0;
   int                   stall_left = 0;

   cache_tag_lookup_fifo_lru_top DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_byte_address (req_byte_address),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_outcome      (rsp_outcome),
      .rsp_victim_tag   (rsp_victim_tag),
      .rsp_access_count (rsp_access_count),
      .rsp_miss_count   (rsp_miss_count),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #6 clock = ~clock;

   // run limit
   initial begin
      #40_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   // idle length: mostly none or short, now and then long
   function automatic int idle_len(input bit quiet);
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // ways, sets and field widths for the current register settings
   function automatic void cache_geometry(output int ways, output int sets,
                                          output int idx_bits, output int off_bits);
      int blocks_log2;
      int blocks;
      blocks_log2 = (shadow_cfg.num_blocks_log2 > MaxBlocksLog2) ?
                    MaxBlocksLog2 : int'(shadow_cfg.num_blocks_log2);
      blocks = 1 << blocks_log2;
      case (shadow_cfg.organization)
         ORG_DIRECT:    ways = 1;
         ORG_SET_ASSOC: ways = (blocks < (1 << SetWaysLog2)) ? blocks : (1 << SetWaysLog2);
         default:       ways = blocks;
      endcase
      sets = blocks / ways;
      idx_bits = $clog2(sets);
      off_bits = int'(shadow_cfg.block_words_log2) + OffsetBase;
   endfunction

   // look one address up in the shadow cache and queue the result word
   task automatic predict_lookup(input logic [ByteAddrW-1:0] addr);
      int                ways, sets, idx_bits, off_bits, idx, base, p, last;
      logic [TagW-1:0]   tag, swap;
      lookup_result_type res;
      bit                done;
      cache_geometry(ways, sets, idx_bits, off_bits);
      idx = int'((addr >> off_bits) & (sets - 1));
      tag = TagW'(addr >> (off_bits + idx_bits));
      base = idx * ways;
      shadow_accesses++;
      res.outcome = OUT_HIT;
      res.victim_tag = '0;
      done = 1'b0;
      // first empty way wins over any later tag match
      for (int w = 0; w < ways && !done; w++) begin
         if (!shadow_valid[base + w]) begin
            shadow_tags[base + w] = tag;
            shadow_valid[base + w] = 1'b1;
            shadow_misses++;
            res.outcome = OUT_FILL;
            done = 1'b1;
         end else if (shadow_tags[base + w] == tag) begin
            // LRU: bubble toward newest end, stop at an empty way
            if (shadow_cfg.replace_policy == POL_LRU) begin
               p = w;
               while (p + 1 < ways && shadow_valid[base + p + 1]) begin
                  swap = shadow_tags[base + p];
                  shadow_tags[base + p] = shadow_tags[base + p + 1];
                  shadow_tags[base + p + 1] = swap;
                  p++;
               end
            end
            done = 1'b1;
         end
      end
      // set full: drop the oldest way, append the new tag
      if (!done) begin
         shadow_misses++;
         res.victim_tag = shadow_tags[base];
         for (int w = 0; w + 1 < ways; w++) begin
            shadow_tags[base + w] = shadow_tags[base + w + 1];
            shadow_valid[base + w] = shadow_valid[base + w + 1];
         end
         last = base + ways - 1;
         shadow_tags[last] = tag;
         shadow_valid[last] = 1'b1;
         res.outcome = OUT_EVICT;
      end
      res.access_count = shadow_accesses;
      res.miss_count = shadow_misses;
      pending_lookups.insert(pending_lookups.size(), res);
   endtask

   // send one address word; returns on the edge that accepts it
   task automatic send_address(input logic [ByteAddrW-1:0] addr);
      int gap;
      if ($urandom_range(0, 39) == 0) req_quiet = !req_quiet;
      gap = idle_len(req_quiet);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_byte_address <= addr;
      do @(posedge clock); while (req_stall);
      predict_lookup(addr);
   endtask

   // stop sending and wait until every result word has come back
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_lookups.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input cfg_index_type idx, input logic [CfgDataW-1:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CFG_NUM_BLOCKS_LOG2:  shadow_cfg.num_blocks_log2 = value;
         CFG_BLOCK_WORDS_LOG2: shadow_cfg.block_words_log2 = value;
         CFG_ORGANIZATION:     shadow_cfg.organization = value[1:0];
         CFG_REPLACE_POLICY:   shadow_cfg.replace_policy = value[0];
         default: ;
      endcase
   endtask

   task automatic program_regs(input logic [CfgDataW-1:0] blocks_log2, words_log2,
                               org_code, policy);
      write_reg(CFG_NUM_BLOCKS_LOG2, blocks_log2);
      write_reg(CFG_BLOCK_WORDS_LOG2, words_log2);
      write_reg(CFG_ORGANIZATION, org_code);
      write_reg(CFG_REPLACE_POLICY, policy);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // reset settings: fill, hit, conflict eviction, top set
   task automatic test_direct_mapped();
      send_address(32'h0000_0000);
      send_address(32'h0000_0003);
      send_address(32'h0000_0400);
      send_address(32'hFFFF_FFFF);
      send_address(32'hFFFF_FFFF);
   endtask

   // direct-mapped contents reread as four-way LRU: gaps inside a set
   task automatic test_stale_layout();
      send_address(32'h0000_000C);
      wait_idle();
      program_regs(4'd8, 4'd0, 4'(ORG_SET_ASSOC), 4'(POL_LRU));
      send_address(32'h0000_0000);
      send_address(32'h0000_0000);
      send_address(32'h0000_0500);
      send_address(32'h0000_0000);
      send_address(32'h0000_0600);
   endtask

   // block count above the array, widest offset, reserved organization code
   task automatic test_oversize_cache();
      wait_idle();
      program_regs(4'hF, 4'hF, {2'b11, OrgReserved}, {3'b111, POL_FIFO});
      send_address(32'hFFFF_FFFF);
      send_address(32'h0002_0000);
      send_address(32'hFFFF_FFFF);
   endtask

   // four-way asked for with only two blocks: one set of two
   task automatic test_tiny_set_assoc();
      wait_idle();
      program_regs(4'd1, 4'd0, 4'(ORG_SET_ASSOC), 4'(POL_LRU));
      send_address(32'h0000_0010);
      send_address(32'h0000_0020);
      send_address(32'h0000_0010);
      send_address(32'h0000_0030);
   endtask

   task automatic test_single_block();
      wait_idle();
      program_regs(4'd0, 4'd0, 4'(ORG_DIRECT), 4'(POL_FIFO));
      send_address(32'h0000_0000);
      send_address(32'h0000_0008);
   endtask

   // random settings per phase; addresses mostly reuse a few tags in a few sets
   task automatic test_random_phases();
      int                   ways, sets, idx_bits, off_bits, pool_n, hot_sets, count;
      logic [ByteAddrW-1:0] tag_pool [12];
      logic [ByteAddrW-1:0] addr;
      logic [3:0]           blocks_log2, words_log2;
      logic [1:0]           org_code, noise;
      logic                 policy;
      for (int ph = 0; ph < 18; ph++) begin
         blocks_log2 = 4'($urandom_range(0, 15));
         org_code = 2'($urandom_range(0, 3));
         policy = 1'($urandom_range(0, 1));
         words_log2 = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) :
                      4'($urandom_range(0, 3));
         // one phase with the full 256-way search, the rest kept quick
         if (ph == 9) begin
            blocks_log2 = 4'($urandom_range(8, 15));
            org_code = 2'($urandom_range(2, 3));
         end else if (org_code >= 2'd2 && blocks_log2 > 4'd5) begin
            blocks_log2 = 4'($urandom_range(0, 5));
         end
         count = (ph == 9) ? 30 : 50;
         noise = 2'($urandom);
         wait_idle();
         program_regs(blocks_log2, words_log2, {noise, org_code},
                      {noise, noise[0], policy});
         cache_geometry(ways, sets, idx_bits, off_bits);
         pool_n = 2 * ways + 1;
         if (pool_n > 12) pool_n = 12;
         hot_sets = (sets < 4) ? sets : 4;
         tag_pool[0] = '1;
         tag_pool[1] = '0;
         for (int i = 2; i < 12; i++) tag_pool[i] = $urandom;
         for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 4) == 0)
               addr = $urandom;
            else
               addr = (tag_pool[$urandom_range(0, pool_n - 1)] << (off_bits + idx_bits))
                    | (ByteAddrW'($urandom_range(0, hot_sets - 1)) << off_bits)
                    | ($urandom & ((1 << off_bits) - 1));
            send_address(addr);
         end
      end
   endtask

   // result side: compare each accepted word, then pick the next stall
   always @(posedge clock) begin : rsp_side
      lookup_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_lookups.size() == 0) begin
            $error("result word with no lookup pending");
            mismatch_count++;
         end else begin
            want = pending_lookups.pop_front();
            if (rsp_outcome !== want.outcome) begin
               $error("outcome: expected %0d, got %0d", want.outcome, rsp_outcome);
               mismatch_count++;
            end
            if (rsp_victim_tag !== want.victim_tag) begin
               $error("victim_tag: expected %h, got %h", want.victim_tag, rsp_victim_tag);
               mismatch_count++;
            end
            if (rsp_access_count !== want.access_count) begin
               $error("access_count: expected %0d, got %0d",
                      want.access_count, rsp_access_count);
               mismatch_count++;
            end
            if (rsp_miss_count !== want.miss_count) begin
               $error("miss_count: expected %0d, got %0d", want.miss_count, rsp_miss_count);
               mismatch_count++;
            end
         end
      end
      if ($urandom_range(0, 299) == 0) rsp_quiet = !rsp_quiet;
      if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
         if ($urandom_range(0, 2) == 0) stall_left = idle_len(rsp_quiet);
      end
   end

   initial begin
      shadow_cfg.num_blocks_log2 = 4'd8;
      shadow_cfg.block_words_log2 = 4'd0;
      shadow_cfg.organization = ORG_DIRECT;
      shadow_cfg.replace_policy = POL_FIFO;
      shadow_accesses = '0;
      shadow_misses = '0;
      for (int i = 0; i < MaxBlocks; i++) begin
         shadow_tags[i] = '0;
         shadow_valid[i] = 1'b0;
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_direct_mapped();
      test_stale_layout();
      test_oversize_cache();
      test_tiny_set_assoc();
      test_single_block();
      test_random_phases();
      wait_idle();
      // allow a stray word to show up
      repeat (600) @(posedge clock);
      if (mismatch_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
